[rtl/ppnc_pkg.sv]
// shared types, constants and band table for the pitch period note classifier
`timescale 1ns / 1ps
`default_nettype none

package ppnc_pkg;

	localparam int CLK_W  = 24;
	localparam int FREQ_W = 16;
	localparam int STR_W  = 3;
	localparam int NOTE_W = 4;
	localparam int OCT_W  = 3;
	localparam int SIGN_W = 2;
	localparam int NUM_BANDS = 6;

	localparam logic [CLK_W-1:0]  CLK_RESET = 24'd1000000;
	localparam logic [FREQ_W-1:0] FREQ_MAX  = 16'hFFFF;
	// below this the low e string still matches but the sign is left alone
	localparam logic [FREQ_W-1:0] E2_SIGN_MIN = 16'd78;

	localparam logic [SIGN_W-1:0] SIGN_FLAT  = 2'd0;
	localparam logic [SIGN_W-1:0] SIGN_TUNED = 2'd1;
	localparam logic [SIGN_W-1:0] SIGN_SHARP = 2'd2;

	typedef struct packed {
		logic [FREQ_W-1:0] lo;
		logic [FREQ_W-1:0] flat_top;
		logic [FREQ_W-1:0] tune_top;
		logic [FREQ_W-1:0] hi;
		logic [STR_W-1:0]  str;
		logic [NOTE_W-1:0] note;
		logic [OCT_W-1:0]  oct;
	} band_t;

	localparam band_t BANDS [NUM_BANDS] = '{
		'{16'd0,   16'd80,  16'd84,  16'd87,  3'd6, 4'd14, 3'd2},
		'{16'd104, 16'd107, 16'd114, 16'd117, 3'd5, 4'd10, 3'd2},
		'{16'd139, 16'd143, 16'd152, 16'd156, 3'd4, 4'd13, 3'd3},
		'{16'd185, 16'd191, 16'd202, 16'd208, 3'd3, 4'd6,  3'd3},
		'{16'd233, 16'd240, 16'd255, 16'd262, 3'd2, 4'd11, 3'd3},
		'{16'd311, 16'd321, 16'd340, 16'd349, 3'd1, 4'd14, 3'd4}
	};

	typedef struct packed {
		logic [STR_W-1:0]  str;
		logic [NOTE_W-1:0] note;
		logic [OCT_W-1:0]  oct;
		logic [SIGN_W-1:0] sign;
		logic              matched;
	} note_res_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

[rtl/pitch_period_note_classifier_core.sv]
// Pitch period note classifier. Each input word is a timer capture taken on a
// rising edge of the signal; the period since the previous capture (modulo
// 2^TIMER_WIDTH) divides the timer_clock_hz register to give the frequency in
// Hz, saturated at 65535 (a zero period also gives 65535). The frequency is
// matched to the six standard-tuning string bands; on a match the string, note,
// octave and tuning sign are updated and held until the next match, and each
// input gives exactly one output word. After an accept the serial restoring
// divider works through the 24-bit numerator one quotient bit at a time and
// then raises its done flag; the block then classifies, loads the output word
// once the output register is free, and returns to idle to take the next
// capture. s_axis_tready is low from the accept until the block is back in
// idle. The output word sits in its own register, so a new capture can be
// taken while the last result waits. cfg_wr loads timer_clock_hz; write it
// only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module pitch_period_note_classifier_core #(
	parameter int TIMER_WIDTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr,
	input  wire logic [ppnc_pkg::CLK_W-1:0] cfg_data,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	// [15:0] capture_time
	input  wire logic [15:0]                s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	// [15:0] frequency_hz, [18:16] string_number, [22:19] note_code,
	// [25:23] octave_number, [27:26] tune_sign, [28] band_matched, [31:29] zero
	output logic [31:0]                     m_axis_tdata
);
	import ppnc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [CLK_W-1:0]       clk_hz_q;
	logic [TIMER_WIDTH-1:0] prev_q;
	logic                   zero_per_q;
	logic                   out_valid_q;
	logic [FREQ_W-1:0]      freq_q;
	note_res_t              res_q;

	logic [TIMER_WIDTH-1:0] cap;
	logic [TIMER_WIDTH-1:0] period;
	logic                   in_acc;
	logic                   out_free;
	logic                   load_out;
	logic [CLK_W-1:0]       quot;
	div_stat_t              div_stat;
	logic [FREQ_W-1:0]      freq;
	note_res_t              nxt;

	assign cap      = TIMER_WIDTH'(s_axis_tdata);
	assign period   = cap - prev_q;
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign load_out = (state_q == ST_DONE) && out_free;

	// saturate on a zero period or a quotient past 16 bits
	always_comb begin
		if (zero_per_q || (|quot[CLK_W-1:FREQ_W])) begin
			freq = FREQ_MAX;
		end else begin
			freq = quot[FREQ_W-1:0];
		end
	end

	ppnc_div #(
		.DEN_W(TIMER_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.numer  (clk_hz_q),
		.denom  (period),
		.quot   (quot),
		.stat   (div_stat)
	);

	ppnc_band u_band (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (load_out),
		.freq   (freq),
		.nxt    (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clk_hz_q    <= CLK_RESET;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				clk_hz_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						prev_q  <= cap;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			zero_per_q <= (period == '0);
		end
		if (load_out) begin
			freq_q <= freq;
			res_q  <= nxt;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, res_q.matched, res_q.sign, res_q.oct, res_q.note,
		res_q.str, freq_q};

endmodule

`default_nettype wire

[rtl/ppnc_div.sv]
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module ppnc_div #(
	parameter int DEN_W = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [ppnc_pkg::CLK_W-1:0] numer,
	input  wire logic [DEN_W-1:0]          denom,
	output logic      [ppnc_pkg::CLK_W-1:0] quot,
	output ppnc_pkg::div_stat_t            stat
);
	import ppnc_pkg::*;

	localparam int CNT_W = $clog2(CLK_W);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CLK_W-1:0] quo_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             fits;

	// next partial remainder with the numerator msb brought down
	always_comb begin
		shifted = {rem_q, quo_q[CLK_W-1]};
		diff    = shifted - {1'b0, den_q};
		fits    = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(CLK_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= denom;
			rem_q <= '0;
			quo_q <= numer;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[CLK_W-2:0], fits};
		end
	end

	assign quot      = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

[rtl/ppnc_band.sv]
// band lookup against the six string bands, with the held note state
`timescale 1ns / 1ps
`default_nettype none

module ppnc_band (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       upd,
	input  wire logic [ppnc_pkg::FREQ_W-1:0] freq,
	output ppnc_pkg::note_res_t             nxt
);
	import ppnc_pkg::*;

	logic [STR_W-1:0]  str_q;
	logic [NOTE_W-1:0] note_q;
	logic [OCT_W-1:0]  oct_q;
	logic [SIGN_W-1:0] sign_q;

	always_comb begin
		logic found;
		found       = 1'b0;
		nxt.str     = str_q;
		nxt.note    = note_q;
		nxt.oct     = oct_q;
		nxt.sign    = sign_q;
		for (int i = 0; i < NUM_BANDS; i++) begin
			if (!found && freq >= BANDS[i].lo && freq <= BANDS[i].hi) begin
				found    = 1'b1;
				nxt.str  = BANDS[i].str;
				nxt.note = BANDS[i].note;
				nxt.oct  = BANDS[i].oct;
				if (i == 0 && freq < E2_SIGN_MIN) begin
					nxt.sign = sign_q;
				end else if (freq <= BANDS[i].flat_top) begin
					nxt.sign = SIGN_FLAT;
				end else if (freq <= BANDS[i].tune_top) begin
					nxt.sign = SIGN_TUNED;
				end else begin
					nxt.sign = SIGN_SHARP;
				end
			end
		end
		nxt.matched = found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			str_q  <= '0;
			note_q <= '0;
			oct_q  <= '0;
			sign_q <= SIGN_FLAT;
		end else if (upd) begin
			str_q  <= nxt.str;
			note_q <= nxt.note;
			oct_q  <= nxt.oct;
			sign_q <= nxt.sign;
		end
	end

endmodule

`default_nettype wire

[rtl/ppnc_checker.sv]
// port-level checks for the pitch period note classifier, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ppnc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);
	import ppnc_pkg::*;

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// the input is seen closed at two points within a division after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##20 !s_axis_tready)
		else $error("input reopened before the division finished");

	// an output word never rises right after an input is taken
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("output word appeared right after an accept");

	// string and sign fields only carry legal codes, and the top three bits are zero
	a_fields_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[18:16] != 3'd7 &&
			(m_axis_tdata[27:26] == SIGN_FLAT || m_axis_tdata[27:26] == SIGN_TUNED ||
			 m_axis_tdata[27:26] == SIGN_SHARP) && m_axis_tdata[31:29] == 3'b000)
		else $error("illegal code in output word");

endmodule

bind pitch_period_note_classifier_core ppnc_checker u_ppnc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
